### rtl/assert_macros.svh
// Assertion macros shared by the classifier RTL.
// Needs clk and arst_n in scope where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define WHC_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define WHC_CHECK_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

### rtl/whc_pkg.sv
// Types, constants and the CORDIC angle table of the hue classifier.
// No dependencies.
package whc_pkg;

	localparam int WINDOW = 10;
	localparam int DEPTH = WINDOW + 1;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int TOT_W = $clog2(1023 * DEPTH + 1);
	localparam int COS_W = $clog2(32767 * DEPTH + 1) + 1;
	localparam int XY_W = COS_W + 10;
	localparam int Z_W = 24;
	localparam int ITERS = 16;
	localparam int ITER_W = $clog2(ITERS);
	localparam int QUEUE_DEPTH = 2;

	// reciprocal of DEPTH, rounded up, exact for every total below 2^TOT_W
	localparam int DIV_SH = TOT_W + PTR_W;
	localparam int DIV_MUL = ((1 << DIV_SH) + DEPTH - 1) / DEPTH;
	localparam int PROD_W = TOT_W + DIV_SH;

	localparam int HUE_W = 12;
	localparam int PCT_W = 10;
	localparam int Q15_W = 16;
	localparam int CORDIC_GAIN = 19898;
	localparam int Q15_MAX = 32767;
	localparam int FULL_TURN = 3600;
	localparam int HALF_TURN = 1800;
	localparam int QUARTER_TURN = 900;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_FROM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_TO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_FROM = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_TO = 3'd6;

	localparam logic [1:0] CLASS_NONE = 2'd0;
	localparam logic [1:0] CLASS_RED = 2'd1;
	localparam logic [1:0] CLASS_BLUE = 2'd2;

	typedef struct packed {
		logic [HUE_W-1:0] hue_sample;
		logic [PCT_W-1:0] sat_sample;
		logic [PCT_W-1:0] bright_sample;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       color_class;
		logic             window_full;
		logic [HUE_W-1:0] mean_hue;
		logic [PCT_W-1:0] mean_sat;
		logic [PCT_W-1:0] mean_bright;
	} out_item_t;

	typedef struct packed {
		logic [PCT_W-1:0] sat_minimum;
		logic [PCT_W-1:0] bright_minimum;
		logic [PCT_W-1:0] bright_maximum;
		logic [HUE_W-1:0] red_hue_from;
		logic [HUE_W-1:0] red_hue_to;
		logic [HUE_W-1:0] blue_hue_from;
		logic [HUE_W-1:0] blue_hue_to;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRIG,
		S_ACC,
		S_ATAN_LD,
		S_ATAN,
		S_CLASS,
		S_DONE
	} eng_state_t;

	// atan(2^-i) in units of 1/2560 degree
	function automatic logic signed [Z_W-1:0] atan_unit(input logic [ITER_W-1:0] idx);
		logic signed [Z_W-1:0] v;
		unique case (idx)
			4'd0: v = 24'sd115200;
			4'd1: v = 24'sd68007;
			4'd2: v = 24'sd35933;
			4'd3: v = 24'sd18240;
			4'd4: v = 24'sd9155;
			4'd5: v = 24'sd4582;
			4'd6: v = 24'sd2292;
			4'd7: v = 24'sd1146;
			4'd8: v = 24'sd573;
			4'd9: v = 24'sd286;
			4'd10: v = 24'sd143;
			4'd11: v = 24'sd72;
			4'd12: v = 24'sd36;
			4'd13: v = 24'sd18;
			4'd14: v = 24'sd9;
			4'd15: v = 24'sd4;
		endcase
		return v;
	endfunction

endpackage

### rtl/whc_queue.sv
// Front part: accepts sensor samples into a short queue for the engine.
// Depends on whc_pkg and assert_macros.svh.
module whc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  whc_pkg::in_item_t in_data,
	output logic            q_valid,
	input  logic            q_pop,
	output whc_pkg::in_item_t q_data
);
	import whc_pkg::*;

	localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	in_item_t mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_q, rd_q;
	logic [QC_W-1:0] count_q;
	logic push, pop;

	assign in_stall = (count_q == QC_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_data = mem_q[rd_q];
	assign push = in_valid & ~in_stall;
	assign pop = q_pop & q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

`include "assert_macros.svh"
	`WHC_CHECK(a_q_count_bound, count_q <= QC_W'(QUEUE_DEPTH), "queue count past depth")
	`WHC_CHECK(a_q_pop_valid, !q_pop || q_valid, "engine popped an empty queue")

endmodule

### rtl/whc_engine.sv
// Back part: window rings, running totals, shared CORDIC, means and class.
// Depends on whc_pkg and assert_macros.svh.
module whc_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  whc_pkg::in_item_t  q_data,
	input  whc_pkg::cfg_t      cfg,
	output logic               out_valid,
	input  logic               out_stall,
	output whc_pkg::out_item_t out_data
);
	import whc_pkg::*;

	eng_state_t state_q, state_nx;
	logic [ITER_W-1:0] it_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic vec_q, flip_q, zero_q;
	logic [PCT_W-1:0] sat_item_q, bri_item_q;

	logic signed [Q15_W-1:0] cos_ring_q [DEPTH];
	logic signed [Q15_W-1:0] sin_ring_q [DEPTH];
	logic [PCT_W-1:0] sat_ring_q [DEPTH];
	logic [PCT_W-1:0] bri_ring_q [DEPTH];

	logic [PTR_W-1:0] ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [TOT_W-1:0] sat_tot_q, bri_tot_q;
	logic signed [COS_W-1:0] cos_tot_q, sin_tot_q;

	out_item_t res_q, out_q;
	logic out_valid_q;

	logic last_it, full, load_out;
	logic pos;
	logic signed [XY_W-1:0] sh_x, sh_y, x_n, y_n, x_f, y_f;
	logic signed [Z_W-1:0] z_n, atan_v, z0;
	logic signed [HUE_W:0] a_w, a_s;
	logic flip0;
	logic signed [Q15_W-1:0] c_new, s_new;
	logic signed [COS_W-1:0] c_old, s_old;
	logic [TOT_W-1:0] sat_old, bri_old;
	logic signed [Z_W-1:0] t_raw, t_w;
	logic [HUE_W-1:0] mh;
	logic limits_ok, is_red, is_blue;
	logic [1:0] cls;
	logic [PROD_W-1:0] sat_prod, bri_prod;

	function automatic logic signed [Q15_W-1:0] clamp_q15(input logic signed [XY_W-1:0] v);
		logic signed [Q15_W-1:0] r;
		if (v > XY_W'(Q15_MAX)) begin
			r = Q15_W'(Q15_MAX);
		end else if (v < -XY_W'(Q15_MAX)) begin
			r = -Q15_W'(Q15_MAX);
		end else begin
			r = v[Q15_W-1:0];
		end
		return r;
	endfunction

	assign last_it = (it_q == ITER_W'(ITERS - 1));
	assign full = (fill_q == FILL_W'(DEPTH));

	// Angle reduction of the incoming hue to -90..90 degrees
	always_comb begin
		a_w = $signed({1'b0, q_data.hue_sample});
		if (a_w >= (HUE_W+1)'(FULL_TURN)) begin
			a_w = a_w - (HUE_W+1)'(FULL_TURN);
		end
		flip0 = 1'b0;
		a_s = a_w;
		if (a_w > (HUE_W+1)'(FULL_TURN - QUARTER_TURN)) begin
			a_s = a_w - (HUE_W+1)'(FULL_TURN);
		end else if (a_w > (HUE_W+1)'(QUARTER_TURN)) begin
			a_s = a_w - (HUE_W+1)'(HALF_TURN);
			flip0 = 1'b1;
		end
		z0 = Z_W'(a_s) <<< 8;
	end

	// Shared CORDIC step: rotation mode steers on z, vectoring mode on y
	always_comb begin
		sh_x = x_q >>> it_q;
		sh_y = y_q >>> it_q;
		atan_v = atan_unit(it_q);
		pos = vec_q ? (y_q < 0) : (z_q >= 0);
		x_n = pos ? x_q - sh_y : x_q + sh_y;
		y_n = pos ? y_q + sh_x : y_q - sh_x;
		z_n = pos ? z_q - atan_v : z_q + atan_v;
	end

	always_comb begin
		x_f = flip_q ? -x_q : x_q;
		y_f = flip_q ? -y_q : y_q;
		c_new = clamp_q15(x_f);
		s_new = clamp_q15(y_f);
		c_old = full ? COS_W'(cos_ring_q[ptr_q]) : '0;
		s_old = full ? COS_W'(sin_ring_q[ptr_q]) : '0;
		sat_old = full ? TOT_W'(sat_ring_q[ptr_q]) : '0;
		bri_old = full ? TOT_W'(bri_ring_q[ptr_q]) : '0;
	end

	// Means by reciprocal multiplication
	always_comb begin
		sat_prod = PROD_W'(sat_tot_q) * PROD_W'(DIV_MUL);
		bri_prod = PROD_W'(bri_tot_q) * PROD_W'(DIV_MUL);
	end

	always_comb begin
		t_raw = (z_q + Z_W'(128)) >>> 8;
		if (t_raw < 0) begin
			t_w = t_raw + Z_W'(FULL_TURN);
		end else if (t_raw >= Z_W'(FULL_TURN)) begin
			t_w = t_raw - Z_W'(FULL_TURN);
		end else begin
			t_w = t_raw;
		end
		mh = zero_q ? '0 : t_w[HUE_W-1:0];
		limits_ok = (sat_tot_q >= TOT_W'(cfg.sat_minimum * DEPTH))
			&& (bri_tot_q >= TOT_W'(cfg.bright_minimum * DEPTH))
			&& (bri_tot_q <= TOT_W'(cfg.bright_maximum * DEPTH));
		if (cfg.red_hue_from > cfg.red_hue_to) begin
			is_red = (mh >= cfg.red_hue_from) || (mh <= cfg.red_hue_to);
		end else begin
			is_red = (mh >= cfg.red_hue_from) && (mh <= cfg.red_hue_to);
		end
		is_blue = (mh >= cfg.blue_hue_from) && (mh <= cfg.blue_hue_to);
		priority if (!limits_ok) begin
			cls = CLASS_NONE;
		end else if (is_red) begin
			cls = CLASS_RED;
		end else if (is_blue) begin
			cls = CLASS_BLUE;
		end else begin
			cls = CLASS_NONE;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (q_valid) begin
				state_nx = S_TRIG;
			end
			S_TRIG: if (last_it) begin
				state_nx = S_ACC;
			end
			S_ACC: state_nx = full ? S_ATAN_LD : S_DONE;
			S_ATAN_LD: state_nx = S_ATAN;
			S_ATAN: if (last_it) begin
				state_nx = S_CLASS;
			end
			S_CLASS: state_nx = S_DONE;
			S_DONE: if (!out_valid_q || !out_stall) begin
				state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == S_IDLE) && q_valid;
		load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			it_q <= '0;
			ptr_q <= '0;
			fill_q <= '0;
			sat_tot_q <= '0;
			bri_tot_q <= '0;
			cos_tot_q <= '0;
			sin_tot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_TRIG || state_q == S_ATAN) begin
				it_q <= it_q + 1'b1;
			end else begin
				it_q <= '0;
			end
			if (state_q == S_ACC) begin
				cos_tot_q <= cos_tot_q - c_old + COS_W'(c_new);
				sin_tot_q <= sin_tot_q - s_old + COS_W'(s_new);
				sat_tot_q <= sat_tot_q - sat_old + TOT_W'(sat_item_q);
				bri_tot_q <= bri_tot_q - bri_old + TOT_W'(bri_item_q);
				ptr_q <= (ptr_q == PTR_W'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				sat_item_q <= q_data.sat_sample;
				bri_item_q <= q_data.bright_sample;
				x_q <= XY_W'(CORDIC_GAIN);
				y_q <= '0;
				z_q <= z0;
				flip_q <= flip0;
				vec_q <= 1'b0;
			end
			S_TRIG, S_ATAN: begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
			end
			S_ACC: begin
				cos_ring_q[ptr_q] <= c_new;
				sin_ring_q[ptr_q] <= s_new;
				sat_ring_q[ptr_q] <= sat_item_q;
				bri_ring_q[ptr_q] <= bri_item_q;
				res_q <= '0;
			end
			S_ATAN_LD: begin
				zero_q <= (cos_tot_q == '0) && (sin_tot_q == '0);
				vec_q <= 1'b1;
				flip_q <= 1'b0;
				// pre-rotate by a half turn when the cosine total is negative
				if (cos_tot_q < 0) begin
					x_q <= -(XY_W'(cos_tot_q) <<< 8);
					y_q <= -(XY_W'(sin_tot_q) <<< 8);
					z_q <= Z_W'(HALF_TURN * 256);
				end else begin
					x_q <= XY_W'(cos_tot_q) <<< 8;
					y_q <= XY_W'(sin_tot_q) <<< 8;
					z_q <= '0;
				end
			end
			S_CLASS: begin
				res_q.color_class <= cls;
				res_q.window_full <= 1'b1;
				res_q.mean_hue <= mh;
				res_q.mean_sat <= sat_prod[DIV_SH +: PCT_W];
				res_q.mean_bright <= bri_prod[DIV_SH +: PCT_W];
			end
			S_DONE: begin
				if (load_out) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`include "assert_macros.svh"
	`WHC_CHECK(a_fill_bound, fill_q <= FILL_W'(DEPTH), "fill count past depth")
	`WHC_CHECK(a_ptr_bound, ptr_q <= PTR_W'(DEPTH - 1), "ring pointer past depth")
	`WHC_CHECK_NEXT(a_load_shows, load_out, out_valid_q, "result not presented after load")
	`WHC_CHECK_NEXT(a_pop_starts, q_pop, state_q == S_TRIG, "popped item did not start")

endmodule

### rtl/windowed_hue_color_classifier_core.sv
// Top level of the windowed hue classifier: registers, sample queue, engine.
// Depends on whc_pkg, whc_queue and whc_engine.
// Each sample runs 16 CORDIC rotation steps for its new hue and, once the window is full,
// 16 vectoring steps for the mean hue.
// The single CORDIC unit is shared, so the engine takes a new sample only after the last result is loaded.
// Reset: configuration registers return to their defaults and the window starts empty.
module windowed_hue_color_classifier_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  whc_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output whc_pkg::out_item_t                  out_data,
	input  logic                                cfg_we,
	input  logic [whc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [whc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import whc_pkg::*;

	cfg_t cfg_q;
	logic q_valid, q_pop;
	in_item_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sat_minimum <= PCT_W'(200);
			cfg_q.bright_minimum <= PCT_W'(50);
			cfg_q.bright_maximum <= PCT_W'(950);
			cfg_q.red_hue_from <= HUE_W'(3500);
			cfg_q.red_hue_to <= HUE_W'(200);
			cfg_q.blue_hue_from <= HUE_W'(2000);
			cfg_q.blue_hue_to <= HUE_W'(2400);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAT_MIN: cfg_q.sat_minimum <= cfg_wdata[PCT_W-1:0];
				CFG_BRIGHT_MIN: cfg_q.bright_minimum <= cfg_wdata[PCT_W-1:0];
				CFG_BRIGHT_MAX: cfg_q.bright_maximum <= cfg_wdata[PCT_W-1:0];
				CFG_RED_FROM: cfg_q.red_hue_from <= cfg_wdata[HUE_W-1:0];
				CFG_RED_TO: cfg_q.red_hue_to <= cfg_wdata[HUE_W-1:0];
				CFG_BLUE_FROM: cfg_q.blue_hue_from <= cfg_wdata[HUE_W-1:0];
				CFG_BLUE_TO: cfg_q.blue_hue_to <= cfg_wdata[HUE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	whc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data)
	);

	whc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
